// File: hw/rtl/pqae_pkg.sv
package pqae_pkg;

  localparam int NUM_COEF = 10;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  // job kinds
  localparam logic [1:0] KIND_D = 2'd0;  // exact n.p accumulate into d
  localparam logic [1:0] KIND_Q = 2'd1;  // coefficient += round(x * weight)
  localparam logic [1:0] KIND_E = 2'd2;  // error += round(x * coefficient)
  localparam logic [1:0] KIND_C = 2'd3;  // error += constant coefficient

  // operand selects for the first product of a job
  localparam logic [2:0] OP_N0  = 3'd0;
  localparam logic [2:0] OP_N1  = 3'd1;
  localparam logic [2:0] OP_N2  = 3'd2;
  localparam logic [2:0] OP_P0  = 3'd3;
  localparam logic [2:0] OP_P1  = 3'd4;
  localparam logic [2:0] OP_P2  = 3'd5;
  localparam logic [2:0] OP_D   = 3'd6;
  localparam logic [2:0] OP_ONE = 3'd7;

  localparam logic [3:0] ADD_LAST_C  = 4'd12;
  localparam logic [3:0] ADD_LAST    = 4'd11;
  localparam logic [3:0] EVAL_LAST_C = 4'd9;
  localparam logic [3:0] EVAL_LAST   = 4'd8;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0] sel_a;
    logic [2:0] sel_b;
    logic [1:0] kind;
    logic [4:0] shift;
    logic [3:0] slot;
  } job_t;

  typedef struct packed {
    logic       mul;
    logic       acc_load;
    logic       acc_add;
    logic       rnd;
    logic       neg;
    logic [4:0] shift;
  } mac_ctl_t;

  function automatic job_t mk_job(input logic [2:0] sel_a, input logic [2:0] sel_b,
                                  input logic [1:0] kind, input logic [4:0] shift,
                                  input logic [3:0] slot);
    job_t j;
    j.sel_a = sel_a;
    j.sel_b = sel_b;
    j.kind  = kind;
    j.shift = shift;
    j.slot  = slot;
    return j;
  endfunction

  function automatic job_t add_job(input logic [3:0] idx);
    job_t j;
    case (idx)
      4'd0:    j = mk_job(OP_N0, OP_P0, KIND_D, 5'd1, 4'd0);
      4'd1:    j = mk_job(OP_N1, OP_P1, KIND_D, 5'd1, 4'd0);
      4'd2:    j = mk_job(OP_N2, OP_P2, KIND_D, 5'd1, 4'd0);
      4'd3:    j = mk_job(OP_N0, OP_N0, KIND_Q, 5'd4, 4'd0);
      4'd4:    j = mk_job(OP_N0, OP_N1, KIND_Q, 5'd4, 4'd1);
      4'd5:    j = mk_job(OP_N0, OP_N2, KIND_Q, 5'd4, 4'd2);
      4'd6:    j = mk_job(OP_N1, OP_N1, KIND_Q, 5'd4, 4'd4);
      4'd7:    j = mk_job(OP_N1, OP_N2, KIND_Q, 5'd4, 4'd5);
      4'd8:    j = mk_job(OP_N2, OP_N2, KIND_Q, 5'd4, 4'd7);
      4'd9:    j = mk_job(OP_N0, OP_D, KIND_Q, 5'd12, 4'd3);
      4'd10:   j = mk_job(OP_N1, OP_D, KIND_Q, 5'd12, 4'd6);
      4'd11:   j = mk_job(OP_N2, OP_D, KIND_Q, 5'd12, 4'd8);
      default: j = mk_job(OP_D, OP_D, KIND_Q, 5'd20, 4'd9);
    endcase
    return j;
  endfunction

  function automatic job_t eval_job(input logic [3:0] idx);
    job_t j;
    case (idx)
      4'd0:    j = mk_job(OP_P0, OP_P0, KIND_E, 5'd16, 4'd0);
      4'd1:    j = mk_job(OP_P1, OP_P1, KIND_E, 5'd16, 4'd4);
      4'd2:    j = mk_job(OP_P2, OP_P2, KIND_E, 5'd16, 4'd7);
      4'd3:    j = mk_job(OP_P0, OP_P1, KIND_E, 5'd15, 4'd1);
      4'd4:    j = mk_job(OP_P0, OP_P2, KIND_E, 5'd15, 4'd2);
      4'd5:    j = mk_job(OP_P1, OP_P2, KIND_E, 5'd15, 4'd5);
      4'd6:    j = mk_job(OP_P0, OP_ONE, KIND_E, 5'd7, 4'd3);
      4'd7:    j = mk_job(OP_P1, OP_ONE, KIND_E, 5'd7, 4'd6);
      4'd8:    j = mk_job(OP_P2, OP_ONE, KIND_E, 5'd7, 4'd8);
      default: j = mk_job(OP_ONE, OP_ONE, KIND_C, 5'd1, 4'd9);
    endcase
    return j;
  endfunction

  // {overflow, value}
  function automatic logic [64:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    logic [64:0] r;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      r = {1'b1, (s[64] ? Q_MIN : Q_MAX)};
    end else begin
      r = {1'b0, s[63:0]};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/pqae_mac.sv
module pqae_mac (
  input  logic               clk,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  pqae_pkg::mac_ctl_t ctl,
  output logic [63:0]        mp,
  output logic [63:0]        rval,
  output logic               rsat
);
  import pqae_pkg::*;

  logic [63:0] mul_out;
  logic [95:0] prod;
  logic [95:0] biased;
  logic [95:0] shifted;
  logic [63:0] mag;
  logic [63:0] val_c;
  logic        sat_c;

  assign mul_out = a * b;

  // round half away from zero on the magnitude, then shift down
  assign biased  = prod + (96'd1 << (ctl.shift - 5'd1));
  assign shifted = biased >> ctl.shift;
  assign mag     = shifted[63:0];

  always_comb begin
    sat_c = 1'b0;
    val_c = mag;
    if (|shifted[95:64]) begin
      sat_c = 1'b1;
      val_c = ctl.neg ? Q_MIN : Q_MAX;
    end else if (!ctl.neg) begin
      if (mag[63]) begin
        sat_c = 1'b1;
        val_c = Q_MAX;
      end
    end else if (mag > Q_MIN) begin
      sat_c = 1'b1;
      val_c = Q_MIN;
    end else begin
      val_c = 64'd0 - mag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      mp <= mul_out;
    end
    if (ctl.acc_load) begin
      prod <= {32'd0, mp};
    end else if (ctl.acc_add) begin
      prod <= prod + {mp, 32'd0};
    end
    if (ctl.rnd) begin
      rval <= val_c;
      rsat <= sat_c;
    end
  end

endmodule

// File: hw/rtl/plane_quadric_accumulate_evaluate.sv
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     command, point_*, normal_*, weight
// result    out        result_valid / result_stall quadric_error, saturated
// config    in         config_write (no wait)      config_data (include_constant_term)
//
// All products go through one 32x32 multiplier; a 64-bit operand takes two passes.
// Clear takes effect as the item is accepted. Add and evaluate step through their job lists,
// evaluate ending in the result register; with the constant term off the last job is skipped.
// A new item is taken while a result still waits; an evaluate then holds at its end.
// Synchronous reset clears the quadric, the overflow flag and sets the constant term on.
module plane_quadric_accumulate_evaluate (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [15:0]        weight,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [63:0] quadric_error,
  output logic               saturated,
  input  logic               config_write,
  input  logic               config_data
);
  import pqae_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PRE  = 4'd1;
  localparam logic [3:0] ST_DACC = 4'd2;
  localparam logic [3:0] ST_M0   = 4'd3;
  localparam logic [3:0] ST_M1   = 4'd4;
  localparam logic [3:0] ST_A1   = 4'd5;
  localparam logic [3:0] ST_RND  = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]  state;
  logic [3:0]  jidx;
  logic        is_eval;
  logic        include_c;
  logic        overflow_seen;
  logic [63:0] coef [NUM_COEF];

  logic [15:0] nm [3];
  logic [15:0] pm [3];
  logic [2:0]  ns;
  logic [2:0]  ps;
  logic [15:0] w;

  logic signed [33:0] d;
  logic [31:0] dm;
  logic        ds;
  logic        sx;
  logic [63:0] x;
  logic [63:0] cm;
  logic        cs;
  logic [63:0] e;

  job_t        job;
  logic [3:0]  last_job;
  logic        accept;
  logic        load_result;
  logic [31:0] opnd [8];
  logic [7:0]  osgn;
  mac_ctl_t    mctl;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mp;
  logic [63:0] rval;
  logic        rsat;

  logic signed [33:0] d_next;
  logic [33:0] d_neg;
  logic [63:0] sum_base;
  logic [63:0] sum_addend;
  logic [64:0] sum_res;

  assign job        = is_eval ? eval_job(jidx) : add_job(jidx);
  assign last_job   = is_eval ? (include_c ? EVAL_LAST_C : EVAL_LAST)
                              : (include_c ? ADD_LAST_C : ADD_LAST);
  assign item_stall = rst | (state != ST_IDLE);
  assign accept     = item_valid & !item_stall;
  assign load_result = (state == ST_FIN) & (!result_valid | !result_stall);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opnd[i]     = {16'd0, nm[i]};
      opnd[i + 3] = {16'd0, pm[i]};
    end
    opnd[OP_D]   = dm;
    opnd[OP_ONE] = 32'd1;
    osgn = {1'b0, ds, ps, ns};
  end

  always_comb begin
    mctl = '0;
    ma   = '0;
    mb   = '0;
    case (state)
      ST_PRE: begin
        mctl.mul = (job.kind != KIND_C);
        ma = opnd[job.sel_a];
        mb = opnd[job.sel_b];
      end
      ST_M0: begin
        mctl.mul = 1'b1;
        if (is_eval) begin
          ma = cm[31:0];
          mb = mp[31:0];
        end else begin
          ma = mp[31:0];
          mb = {16'd0, w};
        end
      end
      ST_M1: begin
        mctl.mul      = 1'b1;
        mctl.acc_load = 1'b1;
        if (is_eval) begin
          ma = cm[63:32];
          mb = x[31:0];
        end else begin
          ma = x[63:32];
          mb = {16'd0, w};
        end
      end
      ST_A1: begin
        mctl.acc_add = 1'b1;
      end
      ST_RND: begin
        mctl.rnd   = 1'b1;
        mctl.neg   = is_eval ? (sx ^ cs) : sx;
        mctl.shift = job.shift;
      end
      default: begin
        mctl = '0;
      end
    endcase
  end

  pqae_mac u_mac (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .ctl  (mctl),
    .mp   (mp),
    .rval (rval),
    .rsat (rsat)
  );

  // d = -(n.p): a positive product is subtracted
  assign d_next = sx ? (d + $signed({2'b00, mp[31:0]})) : (d - $signed({2'b00, mp[31:0]}));
  assign d_neg  = 34'd0 - d_next;

  assign sum_base   = is_eval ? e : coef[job.slot];
  assign sum_addend = (job.kind == KIND_C) ? coef[job.slot] : rval;
  assign sum_res    = sat_add(sum_base, sum_addend);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      jidx          <= '0;
      is_eval       <= 1'b0;
      include_c     <= 1'b1;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else begin
      if (config_write) begin
        include_c <= config_data;
      end

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            jidx <= '0;
            case (command)
              CMD_CLEAR: begin
                overflow_seen <= 1'b0;
                for (int i = 0; i < NUM_COEF; i++) begin
                  coef[i] <= '0;
                end
              end
              CMD_ADD: begin
                is_eval <= 1'b0;
                state   <= ST_PRE;
              end
              CMD_EVAL: begin
                is_eval <= 1'b1;
                state   <= ST_PRE;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PRE: begin
          if (job.kind == KIND_C) begin
            state <= ST_SUM;
          end else if (job.kind == KIND_D) begin
            state <= ST_DACC;
          end else begin
            state <= ST_M0;
          end
        end
        ST_DACC: begin
          jidx  <= jidx + 4'd1;
          state <= ST_PRE;
        end
        ST_M0:  state <= ST_M1;
        ST_M1:  state <= ST_A1;
        ST_A1:  state <= ST_RND;
        ST_RND: state <= ST_SUM;
        ST_SUM: begin
          if (!is_eval) begin
            coef[job.slot] <= sum_res[63:0];
          end
          if (sum_res[64] | ((job.kind != KIND_C) & rsat)) begin
            overflow_seen <= 1'b1;
          end
          if (jidx == last_job) begin
            state <= is_eval ? ST_FIN : ST_IDLE;
          end else begin
            jidx  <= jidx + 4'd1;
            state <= ST_PRE;
          end
        end
        ST_FIN: begin
          if (load_result) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      nm[0] <= normal_x[15] ? 16'(16'd0 - normal_x) : normal_x;
      nm[1] <= normal_y[15] ? 16'(16'd0 - normal_y) : normal_y;
      nm[2] <= normal_z[15] ? 16'(16'd0 - normal_z) : normal_z;
      pm[0] <= point_x[15] ? 16'(16'd0 - point_x) : point_x;
      pm[1] <= point_y[15] ? 16'(16'd0 - point_y) : point_y;
      pm[2] <= point_z[15] ? 16'(16'd0 - point_z) : point_z;
      ns    <= {normal_z[15], normal_y[15], normal_x[15]};
      ps    <= {point_z[15], point_y[15], point_x[15]};
      w     <= weight;
      d     <= '0;
      e     <= '0;
    end
    if (state == ST_PRE) begin
      sx <= osgn[job.sel_a] ^ osgn[job.sel_b];
      cm <= coef[job.slot][63] ? (64'd0 - coef[job.slot]) : coef[job.slot];
      cs <= coef[job.slot][63];
    end
    if (state == ST_DACC) begin
      d  <= d_next;
      dm <= d_next[33] ? d_neg[31:0] : d_next[31:0];
      ds <= d_next[33];
    end
    if (state == ST_M0) begin
      x <= mp;
    end
    if ((state == ST_SUM) && is_eval) begin
      e <= sum_res[63:0];
    end
    if (load_result) begin
      quadric_error <= $signed(e);
      saturated     <= overflow_seen;
    end
  end

endmodule

// File: verif/tb_plane_quadric_accumulate_evaluate.sv
module tb_plane_quadric_accumulate_evaluate;
  import pqae_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // coefficient slots: A00 A01 A02 b0 A11 A12 b1 A22 b2 c
  localparam int SLOT_XX = 0;
  localparam int SLOT_XY = 1;
  localparam int SLOT_XZ = 2;
  localparam int SLOT_X  = 3;
  localparam int SLOT_YY = 4;
  localparam int SLOT_YZ = 5;
  localparam int SLOT_Y  = 6;
  localparam int SLOT_ZZ = 7;
  localparam int SLOT_Z  = 8;
  localparam int SLOT_C  = 9;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 100;
  localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [15:0] w;
  } plane_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } error_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         command = CMD_CLEAR;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic signed [15:0] point_z = '0;
  logic signed [15:0] normal_x = '0;
  logic signed [15:0] normal_y = '0;
  logic signed [15:0] normal_z = '0;
  logic [15:0]        weight = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [63:0] quadric_error;
  logic               saturated;
  logic               config_write = 1'b0;
  logic               config_data = 1'b1;

  plane_quadric_accumulate_evaluate dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .weight       (weight),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .quadric_error(quadric_error),
    .saturated    (saturated),
    .config_write (config_write),
    .config_data  (config_data)
  );

  always #2 clk = ~clk;

  plane_item_t pending_items[$];
  error_beat_t expected_errors[$];

  logic signed [63:0] coef [NUM_COEF];
  logic overflow_flag = 1'b0;
  logic const_mode = 1'b1;
  logic step_sat;
  logic burst_mode = 1'b0;
  logic sending = 1'b0;
  int   errors = 0;
  int   cycle_count = 0;

  initial begin
    for (int i = 0; i < NUM_COEF; i++) coef[i] = '0;
  end

  function automatic logic [63:0] magnitude(input logic signed [63:0] x);
    return x[63] ? -x : x;
  endfunction

  // sign * ma * mb / 2^sh, round half away from zero, clamp to 64 bits
  function automatic logic signed [63:0] scale_round(input logic neg, input logic [63:0] ma,
                                                     input logic [63:0] mb, input int sh);
    logic [127:0] prod;
    logic [127:0] shifted;
    logic [63:0]  m;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod + (128'd1 << (sh - 1));
    shifted = prod >> sh;
    if (shifted[127:64] != '0) begin
      step_sat = 1'b1;
      return neg ? Q_MIN : Q_MAX;
    end
    m = shifted[63:0];
    if (!neg) begin
      if (m[63]) begin
        step_sat = 1'b1;
        return Q_MAX;
      end
      return m;
    end
    if (m > TOP_BIT) begin
      step_sat = 1'b1;
      return Q_MIN;
    end
    return -m;
  endfunction

  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      step_sat = 1'b1;
      return s[64] ? Q_MIN : Q_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] normal_pair_inc(input logic signed [63:0] nn,
                                                         input logic [63:0] w);
    return scale_round(nn[63], magnitude(nn), w, 4);
  endfunction

  function automatic logic signed [63:0] offset_inc(input logic signed [63:0] n,
                                                    input logic signed [63:0] d,
                                                    input logic [63:0] w);
    return scale_round(n[63] != d[63], magnitude(n) * magnitude(d), w, 12);
  endfunction

  function automatic logic signed [63:0] eval_term(input logic signed [63:0] small_val,
                                                   input logic signed [63:0] c, input int sh);
    return scale_round(small_val[63] != c[63], magnitude(small_val), magnitude(c), sh);
  endfunction

  // update the quadric copy for one accepted item; queue the error an evaluate will return
  task automatic apply_item(input plane_item_t it);
    logic signed [63:0] p0, p1, p2, n0, n1, n2, d, e;
    logic [63:0] w;
    error_beat_t beat;
    step_sat = 1'b0;
    p0 = $signed(it.px);
    p1 = $signed(it.py);
    p2 = $signed(it.pz);
    n0 = $signed(it.nx);
    n1 = $signed(it.ny);
    n2 = $signed(it.nz);
    w = {48'd0, it.w};
    case (it.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_COEF; i++) coef[i] = '0;
        overflow_flag = 1'b0;
      end
      CMD_ADD: begin
        d = -(n0 * p0 + n1 * p1 + n2 * p2);
        coef[SLOT_XX] = clamp_add(coef[SLOT_XX], normal_pair_inc(n0 * n0, w));
        coef[SLOT_XY] = clamp_add(coef[SLOT_XY], normal_pair_inc(n0 * n1, w));
        coef[SLOT_XZ] = clamp_add(coef[SLOT_XZ], normal_pair_inc(n0 * n2, w));
        coef[SLOT_YY] = clamp_add(coef[SLOT_YY], normal_pair_inc(n1 * n1, w));
        coef[SLOT_YZ] = clamp_add(coef[SLOT_YZ], normal_pair_inc(n1 * n2, w));
        coef[SLOT_ZZ] = clamp_add(coef[SLOT_ZZ], normal_pair_inc(n2 * n2, w));
        coef[SLOT_X] = clamp_add(coef[SLOT_X], offset_inc(n0, d, w));
        coef[SLOT_Y] = clamp_add(coef[SLOT_Y], offset_inc(n1, d, w));
        coef[SLOT_Z] = clamp_add(coef[SLOT_Z], offset_inc(n2, d, w));
        if (const_mode)
          coef[SLOT_C] = clamp_add(coef[SLOT_C],
                                   scale_round(1'b0, magnitude(d) * magnitude(d), w, 20));
        if (step_sat) overflow_flag = 1'b1;
      end
      CMD_EVAL: begin
        e = '0;
        e = clamp_add(e, eval_term(p0 * p0, coef[SLOT_XX], 16));
        e = clamp_add(e, eval_term(p1 * p1, coef[SLOT_YY], 16));
        e = clamp_add(e, eval_term(p2 * p2, coef[SLOT_ZZ], 16));
        e = clamp_add(e, eval_term(p0 * p1, coef[SLOT_XY], 15));
        e = clamp_add(e, eval_term(p0 * p2, coef[SLOT_XZ], 15));
        e = clamp_add(e, eval_term(p1 * p2, coef[SLOT_YZ], 15));
        e = clamp_add(e, eval_term(p0, coef[SLOT_X], 7));
        e = clamp_add(e, eval_term(p1, coef[SLOT_Y], 7));
        e = clamp_add(e, eval_term(p2, coef[SLOT_Z], 7));
        if (const_mode) e = clamp_add(e, coef[SLOT_C]);
        if (step_sat) overflow_flag = 1'b1;
        beat.value = e;
        beat.sat = overflow_flag;
        expected_errors.push_back(beat);
      end
      default: ;
    endcase
  endtask

  function automatic int pick_idle();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_field();
    logic [15:0] v;
    case ($urandom_range(0, 11))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      4: v = 16'($urandom_range(0, 1023) - 512);
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  function automatic plane_item_t mk_item(input logic [1:0] cmd,
                                          input logic [15:0] px, input logic [15:0] py,
                                          input logic [15:0] pz, input logic [15:0] nx,
                                          input logic [15:0] ny, input logic [15:0] nz,
                                          input logic [15:0] w);
    plane_item_t it;
    it.cmd = cmd;
    it.px = px;
    it.py = py;
    it.pz = pz;
    it.nx = nx;
    it.ny = ny;
    it.nz = nz;
    it.w = w;
    return it;
  endfunction

  function automatic plane_item_t rand_item(input logic [1:0] cmd);
    logic [15:0] w;
    w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 512)) : pick_field();
    return mk_item(cmd, pick_field(), pick_field(), pick_field(),
                   pick_field(), pick_field(), pick_field(), w);
  endfunction

  // extreme plane: |d| near 3 * 2^30, drives the constant coefficient to its limit
  function automatic plane_item_t extreme_plane();
    logic [15:0] n;
    n = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return mk_item(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, n, n, n, 16'hFFFF);
  endfunction

  task automatic gen_phase(input int target);
    int made;
    int r;
    int k;
    made = 0;
    while (made < target) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        pending_items.push_back(rand_item(CMD_UNUSED));
      end else if (r < 10) begin
        pending_items.push_back(rand_item(CMD_CLEAR));
        made++;
      end else if (r < 13) begin
        repeat (16) pending_items.push_back(extreme_plane());
        pending_items.push_back(rand_item(CMD_EVAL));
        made += 17;
      end else begin
        k = $urandom_range(0, 4);
        repeat (k) pending_items.push_back(rand_item(CMD_ADD));
        made += k;
        k = $urandom_range(1, 2);
        repeat (k) pending_items.push_back(rand_item(CMD_EVAL));
        made += k;
      end
    end
  endtask

  // adds give no beat back, so leave room for one to finish after the last result
  task automatic wait_idle();
    while (pending_items.size() != 0 || sending || expected_errors.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic v);
    wait_idle();
    config_write <= 1'b1;
    config_data <= v;
    @(posedge clk);
    config_write <= 1'b0;
    const_mode = v;
  endtask

  // sender
  int          send_gap = 0;
  plane_item_t driven;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (sending && !item_stall) begin
        apply_item(driven);
        sending = 1'b0;
        send_gap = pick_idle();
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() != 0) begin
          driven = pending_items.pop_front();
          sending = 1'b1;
          command <= driven.cmd;
          point_x <= driven.px;
          point_y <= driven.py;
          point_z <= driven.pz;
          normal_x <= driven.nx;
          normal_y <= driven.ny;
          normal_z <= driven.nz;
          weight <= driven.w;
        end
      end
      item_valid <= sending;
    end
  end

  // receiver
  int          hold_left = 0;
  int          recv_run = 0;
  int          recv_gap = 0;
  int          results_seen = 0;
  logic        stall_next;
  error_beat_t got;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_errors.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: quadric_error %0d saturated %0b",
                   $time, quadric_error, saturated);
        end else begin
          got = expected_errors.pop_front();
          if (quadric_error !== got.value) begin
            errors++;
            $display("%0t: quadric_error expected %0d, got %0d",
                     $time, $signed(got.value), quadric_error);
          end
          if (saturated !== got.sat) begin
            errors++;
            $display("%0t: saturated expected %0b, got %0b", $time, got.sat, saturated);
          end
        end
        // long hold-off so the block backs up and stalls its input
        if (results_seen == 40 || results_seen == 250) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (recv_run > 0) begin
        recv_run--;
        stall_next = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        stall_next = 1'b1;
      end else begin
        recv_gap = pick_idle();
        recv_run = $urandom_range(0, 6);
        stall_next = (recv_gap > 0);
        if (recv_gap > 0) recv_gap--;
      end
      result_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, constant term on from reset
    pending_items.push_back(mk_item(CMD_EVAL, 16'h7FFF, 16'h8000, 16'h0001,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_items.push_back(mk_item(CMD_ADD, 16'h7FFF, 16'h8000, 16'hFFFF,
                                    16'h8000, 16'h7FFF, 16'h0000, 16'h0000));
    pending_items.push_back(rand_item(CMD_UNUSED));
    pending_items.push_back(mk_item(CMD_EVAL, 16'h0100, 16'h0100, 16'h0100,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0000));
    repeat (4) pending_items.push_back(mk_item(CMD_ADD, 16'h8000, 16'h8000, 16'h8000,
                                               16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
    // positive point with every coefficient positive: result clamps
    pending_items.push_back(mk_item(CMD_EVAL, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_items.push_back(mk_item(CMD_EVAL, 16'h8000, 16'h8000, 16'h8000,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_items.push_back(mk_item(CMD_EVAL, 16'h0000, 16'h0000, 16'h0000,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_items.push_back(mk_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_items.push_back(mk_item(CMD_EVAL, 16'h0064, 16'hFF9C, 16'h0000,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_items.push_back(mk_item(CMD_ADD, 16'h0100, 16'h0200, 16'hFF00,
                                    16'h4000, 16'h0000, 16'h0000, 16'h0100));
    pending_items.push_back(mk_item(CMD_ADD, 16'hFB00, 16'h0300, 16'h0000,
                                    16'h0000, 16'hC000, 16'h0000, 16'h0080));
    pending_items.push_back(mk_item(CMD_ADD, 16'h0001, 16'hFFFF, 16'h7FFF,
                                    16'h2D41, 16'h2D41, 16'h0000, 16'h0001));
    pending_items.push_back(mk_item(CMD_EVAL, 16'h0200, 16'hFE00, 16'h0100,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_items.push_back(mk_item(CMD_EVAL, 16'h8000, 16'h7FFF, 16'h8000,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0000));

    for (phase = 0; phase < 6; phase++) begin
      set_mode(phase[0]);
      burst_mode = (phase == 3);
      gen_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
